// ===== sv/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache model.
package salc_pkg;

	localparam int MAX_SET_BITS = 8;
	localparam int MAX_WAYS     = 8;

	localparam int SETS   = 1 << MAX_SET_BITS;
	localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NW_W   = $clog2(MAX_WAYS + 1);
	localparam int CFG_W  = 6;
	localparam int CFG_IW = 2;

	// access kinds
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_STORE  = 2'd1;
	localparam logic [1:0] KIND_MODIFY = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_WAYS_USED  = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] address;
	} acc_word_t;

	typedef struct packed {
		logic [1:0]  hits;
		logic        missed;
		logic        evicted;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
	} res_word_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] tag;
		logic [63:0] stamp;
	} line_t;

	typedef line_t [MAX_WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic accept;   // take the input word, start the set read
		logic capture;  // register the set and the tag/stamp compares
		logic commit;   // write back, count, load the result
	} ctrl_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_status_t;

endpackage

// ===== sv/salc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/salc_ctrl.sv =====
// Sequencer for one cache access: accept, compare, commit.
module salc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  acc_valid,
	output logic                  acc_stall,
	input  salc_pkg::dp_status_t  status,
	output salc_pkg::ctrl_cmd_t   cmd
);
	import salc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_WR   = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd.accept  = (state_q == ST_IDLE) && acc_valid;
		cmd.capture = (state_q == ST_CMP);
		cmd.commit  = (state_q == ST_WR) && status.slot_free;
		acc_stall   = (state_q != ST_IDLE);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc_valid) state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				if (status.slot_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_then_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.capture)
		else $error("compare stage did not follow an accepted word");

	a_capture_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> $past(cmd.accept))
		else $error("compare stage without an accepted word");

endmodule

// ===== sv/salc_dp.sv =====
// Datapath: address split, set store, hit and LRU victim logic, counters.
module salc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [salc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [salc_pkg::CFG_W-1:0]  cfg_data,
	input  salc_pkg::acc_word_t   acc_word,
	output logic                  res_valid,
	input  logic                  res_stall,
	output salc_pkg::res_word_t   res_word,
	input  salc_pkg::ctrl_cmd_t   cmd,
	output salc_pkg::dp_status_t  status
);
	import salc_pkg::*;

	function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [1:0] inc);
		logic [32:0] sum;
		sum = {1'b0, v} + 33'(inc);
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// configuration
	logic [3:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			ways_used_q  <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[5:0];
				CFG_WAYS_USED:  ways_used_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// address split
	logic [3:0]          sb_eff;
	logic [NW_W-1:0]     nw_eff;
	logic [6:0]          tag_shift;
	logic [63:0]         addr_sh;
	logic [SET_W-1:0]    set_mask;
	logic [SET_W-1:0]    set_idx;
	logic [63:0]         tag_in;
	logic [MAX_WAYS-1:0] cand;

	always_comb begin
		if (int'(set_bits_q) > MAX_SET_BITS) sb_eff = 4'(MAX_SET_BITS);
		else sb_eff = set_bits_q;
		if (ways_used_q == '0) nw_eff = NW_W'(1);
		else if (int'(ways_used_q) > MAX_WAYS) nw_eff = NW_W'(MAX_WAYS);
		else nw_eff = NW_W'(ways_used_q);
		tag_shift = {3'b000, sb_eff} + {1'b0, block_bits_q};
		addr_sh   = acc_word.address >> block_bits_q;
		set_mask  = ~({SET_W{1'b1}} << sb_eff);
		set_idx   = addr_sh[SET_W-1:0] & set_mask;
		tag_in    = (tag_shift >= 7'd64) ? 64'd0 : (acc_word.address >> tag_shift);
		for (int w = 0; w < MAX_WAYS; w++) begin
			cand[w] = NW_W'(w) < nw_eff;
		end
	end

	// accept stage
	logic [SET_W-1:0]    set_q;
	logic [63:0]         tag_q;
	logic [1:0]          kind_q;
	logic [MAX_WAYS-1:0] cand_q;
	logic                rowv_q;
	logic [SETS-1:0]     row_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_q  <= set_idx;
			tag_q  <= tag_in;
			kind_q <= acc_word.kind;
			cand_q <= cand;
			rowv_q <= row_valid_q[set_idx];
		end
	end

	// set store
	logic [ROW_W-1:0] ram_rdata;
	row_t             row_wr;
	logic             is_access;

	salc_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.commit && is_access),
		.wr_addr (set_q),
		.wr_data (ROW_W'(row_wr)),
		.rd_en   (cmd.accept),
		.rd_addr (set_idx),
		.rd_data (ram_rdata)
	);

	// compare stage
	row_t                               line_rd;
	row_t                               line_q;
	logic [MAX_WAYS-1:0]                match_q;
	logic [MAX_WAYS-1:0][MAX_WAYS-1:0]  lt_q;   // lt_q[i][j]: stamp i below stamp j

	assign line_rd = rowv_q ? row_t'(ram_rdata) : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			line_q <= line_rd;
			for (int i = 0; i < MAX_WAYS; i++) begin
				match_q[i] <= cand_q[i] && line_rd[i].valid && (line_rd[i].tag == tag_q);
				for (int j = 0; j < MAX_WAYS; j++) begin
					lt_q[i][j] <= line_rd[i].stamp < line_rd[j].stamp;
				end
			end
		end
	end

	// commit stage
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] victim;
	logic [WAY_W-1:0] sel_way;
	logic             hit;
	logic             modify;
	logic             found;
	logic             ok;
	logic [1:0]       hits_d;
	logic             missed_d;
	logic             evicted_d;
	logic [63:0]      stamp_q;
	logic [63:0]      stamp_new;
	logic [31:0]      hit_cnt_q, miss_cnt_q, evict_cnt_q;
	logic [31:0]      hit_cnt_d, miss_cnt_d, evict_cnt_d;

	always_comb begin
		hit_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (match_q[w]) hit_way = WAY_W'(w);
		end
		// oldest candidate, ties to the lowest way
		victim = '0;
		found  = 1'b0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			ok = cand_q[i];
			for (int j = 0; j < MAX_WAYS; j++) begin
				if (j < i && cand_q[j] && !lt_q[i][j]) ok = 1'b0;
				if (j > i && cand_q[j] && lt_q[j][i]) ok = 1'b0;
			end
			if (ok && !found) begin
				victim = WAY_W'(i);
				found  = 1'b1;
			end
		end
	end

	always_comb begin
		is_access = (kind_q != KIND_NONE);
		hit       = |match_q;
		modify    = (kind_q == KIND_MODIFY);
		sel_way   = hit ? hit_way : victim;
		// second half of a modify always hits the same way
		stamp_new = stamp_q + 64'(modify);
		hits_d    = is_access ? (2'(hit) + 2'(modify)) : 2'd0;
		missed_d  = is_access && !hit;
		evicted_d = is_access && !hit && line_q[victim].valid;
		hit_cnt_d   = sat_add(hit_cnt_q, hits_d);
		miss_cnt_d  = sat_add(miss_cnt_q, {1'b0, missed_d});
		evict_cnt_d = sat_add(evict_cnt_q, {1'b0, evicted_d});
		row_wr = line_q;
		row_wr[sel_way].valid = 1'b1;
		row_wr[sel_way].tag   = tag_q;
		row_wr[sel_way].stamp = stamp_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q     <= 64'd1;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
			row_valid_q <= '0;
		end else if (cmd.commit && is_access) begin
			stamp_q              <= stamp_new + 64'd1;
			hit_cnt_q            <= hit_cnt_d;
			miss_cnt_q           <= miss_cnt_d;
			evict_cnt_q          <= evict_cnt_d;
			row_valid_q[set_q]   <= 1'b1;
		end
	end

	// output register
	logic      res_valid_q;
	res_word_t res_q;

	assign status.slot_free = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res_word  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.hits           <= hits_d;
			res_q.missed         <= missed_d;
			res_q.evicted        <= evicted_d;
			res_q.hit_total      <= hit_cnt_d;
			res_q.miss_total     <= miss_cnt_d;
			res_q.eviction_total <= evict_cnt_d;
		end
	end

	a_commit_fills_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> res_valid_q)
		else $error("committed word not presented");

	a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (!res_q.evicted || res_q.missed))
		else $error("eviction reported without a miss");

	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_access) |=> row_valid_q[$past(set_q)])
		else $error("written set not marked valid");

endmodule

// ===== sv/set_assoc_lru_cache_model.sv =====
// Top level: set-associative cache with true LRU replacement, trace replay.
//
//   channel   dir  handshake              word
//   acc       in   acc_valid / acc_stall  acc_word: kind, address
//   res       out  res_valid / res_stall  res_word: hits, missed, evicted, totals
//   cfg       in   cfg_we                 cfg_index, cfg_data
//
// Each word passes three steps: accept (set read issued), compare (row held,
// tag and stamp compares), commit (row written back, counters, result).
// The single set store read port and the read-modify-write of one row call for these steps.
// Reset clears the per-set valid flags at once; there is no clearing pass.
// A result held by res_stall parks the sequencer in commit; the next input
// word is not taken until that result has a free slot.
// A modify word counts as two accesses; the second always hits.
module set_assoc_lru_cache_model (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         acc_valid,
	output logic                         acc_stall,
	input  salc_pkg::acc_word_t          acc_word,
	output logic                         res_valid,
	input  logic                         res_stall,
	output salc_pkg::res_word_t          res_word,
	input  logic                         cfg_we,
	input  logic [salc_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [salc_pkg::CFG_W-1:0]   cfg_data
);
	import salc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// sequencer: one access in flight at a time
	salc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc_valid),
		.acc_stall (acc_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// address split, set store, LRU choice, saturating totals
	salc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc_word  (acc_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative LRU cache model.
module tb_top;

	import salc_pkg::*;

	localparam int LINES = SETS * MAX_WAYS;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// block inputs start known, before the first edge
	logic                acc_valid = 1'b0;
	acc_word_t           acc_word  = '0;
	logic                res_stall = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFG_IW-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data  = '0;
	logic                acc_stall;
	logic                res_valid;
	res_word_t           res_word;

	set_assoc_lru_cache_model i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc_valid),
		.acc_stall (acc_stall),
		.acc_word  (acc_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// words waiting to be sent, and the outcomes the cache should report
	acc_word_t access_q[$];
	res_word_t outcome_q[$];

	// idling levels in percent, set per phase
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	int unsigned fail_cnt     = 0;
	int unsigned checked_cnt  = 0;
	int unsigned geometry_cnt = 0;

	// shadow of the geometry registers
	logic [3:0] geo_set_bits   = 4'd0;
	logic [5:0] geo_block_bits = 6'd0;
	logic [3:0] geo_ways       = 4'd1;

	// shadow cache: way w of set s at entry s * MAX_WAYS + w
	logic        line_ok [LINES];
	logic [63:0] line_tag[LINES];
	logic [63:0] line_age[LINES];
	logic [63:0] stamp_now;
	logic [31:0] hit_cnt, miss_cnt, evict_cnt;

	// One cache access on the shadow; lowest matching way hits, otherwise the
	// way with the oldest stamp is refilled (ties to the lowest way).
	task automatic touch_line(input logic [63:0] addr, output logic hit, output logic ev);
		int unsigned sb, bb, nw, base, victim, w;
		logic [63:0] set_idx, tag;
		sb = (geo_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : 32'(geo_set_bits);
		bb = 32'(geo_block_bits);
		nw = (geo_ways == 0) ? 1 : ((geo_ways > MAX_WAYS) ? MAX_WAYS : 32'(geo_ways));
		set_idx = (addr >> bb) & ((64'd1 << sb) - 64'd1);
		// shifting the whole address away leaves a zero tag
		tag = (sb + bb >= 64) ? 64'd0 : (addr >> (sb + bb));
		base = int'(set_idx) * MAX_WAYS;
		hit = 1'b0;
		ev = 1'b0;
		for (w = 0; w < nw; w++) begin
			if (!hit && line_ok[base + w] && line_tag[base + w] == tag) begin
				hit = 1'b1;
				line_age[base + w] = stamp_now;
			end
		end
		if (hit) begin
			if (hit_cnt != '1) hit_cnt++;
		end else begin
			if (miss_cnt != '1) miss_cnt++;
			victim = 0;
			for (w = 1; w < nw; w++)
				if (line_age[base + w] < line_age[base + victim]) victim = w;
			if (line_ok[base + victim]) begin
				ev = 1'b1;
				if (evict_cnt != '1) evict_cnt++;
			end
			line_ok[base + victim] = 1'b1;
			line_tag[base + victim] = tag;
			line_age[base + victim] = stamp_now;
		end
		stamp_now++;
	endtask

	// Works out the result word for one accepted access word.
	task automatic predict_outcome(input acc_word_t a);
		res_word_t r;
		logic h, e;
		r = '0;
		if (a.kind != KIND_NONE) begin
			touch_line(a.address, h, e);
			if (h) r.hits = r.hits + 2'd1;
			else r.missed = 1'b1;
			if (e) r.evicted = 1'b1;
			// second half of a modify always finds the line just touched
			if (a.kind == KIND_MODIFY) begin
				touch_line(a.address, h, e);
				if (h) r.hits = r.hits + 2'd1;
				if (e) r.evicted = 1'b1;
			end
		end
		r.hit_total = hit_cnt;
		r.miss_total = miss_cnt;
		r.eviction_total = evict_cnt;
		outcome_q.push_back(r);
	endtask

	// Driver: predicts on acceptance, then loads the next word or idles.
	always @(posedge clk) begin
		if (!arst_n) begin
			acc_valid <= 1'b0;
		end else begin
			if (acc_valid && !acc_stall)
				predict_outcome(acc_word);
			// a stalled word stays put; otherwise the slot is free
			if (!acc_valid || !acc_stall) begin
				if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					acc_word <= access_q.pop_front();
					acc_valid <= 1'b1;
				end else begin
					acc_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result word against the oldest outcome.
	always @(posedge clk) begin
		res_word_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				checked_cnt++;
				if (outcome_q.size() == 0) begin
					$error("result word with no outcome pending");
					fail_cnt++;
				end else begin
					want = outcome_q.pop_front();
					if (res_word.hits !== want.hits) begin
						$error("hits: expected %0d, actual %0d", want.hits, res_word.hits);
						fail_cnt++;
					end
					if (res_word.missed !== want.missed) begin
						$error("missed: expected %0d, actual %0d", want.missed, res_word.missed);
						fail_cnt++;
					end
					if (res_word.evicted !== want.evicted) begin
						$error("evicted: expected %0d, actual %0d",
							want.evicted, res_word.evicted);
						fail_cnt++;
					end
					if (res_word.hit_total !== want.hit_total) begin
						$error("hit_total: expected %0d, actual %0d",
							want.hit_total, res_word.hit_total);
						fail_cnt++;
					end
					if (res_word.miss_total !== want.miss_total) begin
						$error("miss_total: expected %0d, actual %0d",
							want.miss_total, res_word.miss_total);
						fail_cnt++;
					end
					if (res_word.eviction_total !== want.eviction_total) begin
						$error("eviction_total: expected %0d, actual %0d",
							want.eviction_total, res_word.eviction_total);
						fail_cnt++;
					end
				end
			end
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Sender holds back until the cache has nothing in flight.
	task automatic wait_drained();
		while (access_q.size() != 0 || acc_valid || outcome_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SET_BITS:   geo_set_bits = val[3:0];
			CFG_BLOCK_BITS: geo_block_bits = val;
			CFG_WAYS_USED:  geo_ways = val[3:0];
			default: ;
		endcase
	endtask

	// New geometry; lines already held are kept and read under it.
	task automatic set_geometry(input logic [CFG_W-1:0] sb, input logic [CFG_W-1:0] bb,
			input logic [CFG_W-1:0] nw);
		wait_drained();
		write_reg(CFG_SET_BITS, sb);
		write_reg(CFG_BLOCK_BITS, bb);
		write_reg(CFG_WAYS_USED, nw);
		geometry_cnt++;
	endtask

	task automatic queue_access(input logic [1:0] k, input logic [63:0] addr);
		acc_word_t a;
		a.kind = k;
		a.address = addr;
		access_q.push_back(a);
	endtask

	// Stimulus
	initial begin
		logic [63:0] hot[$];
		logic [63:0] offs_mask, addr;
		logic [CFG_W-1:0] sb, bb, nw;
		int unsigned pick, burst, n, i, p;

		for (i = 0; i < LINES; i++) begin
			line_ok[i] = 1'b0;
			line_tag[i] = '0;
			line_age[i] = '0;
		end
		stamp_now = 64'd1;
		hit_cnt = '0;
		miss_cnt = '0;
		evict_cnt = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: one set, one way after reset
		queue_access(KIND_LOAD, 64'd0);                    // cold miss, free way
		queue_access(KIND_LOAD, 64'd0);                    // hit
		queue_access(KIND_STORE, '1);                      // miss, evicts
		queue_access(KIND_MODIFY, '1);                     // two hits
		queue_access(KIND_NONE, 64'h5555_5555_5555_5555);  // no access
		queue_access(KIND_MODIFY, 64'h8000_0000_0000_0000); // miss then hit
		queue_access(KIND_NONE, '1);
		queue_access(KIND_LOAD, 64'd0);

		// set bits past the maximum, tag shifted out entirely, ways past the maximum
		set_geometry(6'd15, 6'd56, 6'd15);
		queue_access(KIND_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
		queue_access(KIND_LOAD, 64'h5555_5555_5555_5555);
		queue_access(KIND_STORE, '1);
		queue_access(KIND_MODIFY, 64'd0);

		// zero ways behaves as one; very wide offset
		set_geometry(6'd2, 6'd63, 6'd0);
		queue_access(KIND_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
		queue_access(KIND_STORE, 64'h8000_0000_0000_0001);
		queue_access(KIND_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);

		// two lines that alias once the offset widens: lowest way must hit
		set_geometry(6'd0, 6'd0, 6'd2);
		queue_access(KIND_LOAD, 64'h10);
		queue_access(KIND_LOAD, 64'h11);
		set_geometry(6'd0, 6'd4, 6'd2);
		queue_access(KIND_LOAD, 64'h10);
		queue_access(KIND_STORE, 64'h1F);
		queue_access(KIND_MODIFY, 64'h20);
		wait_drained();

		// random phases: geometry and idling change between them
		for (p = 0; p < 12; p++) begin
			case (p)
				0:       begin sb = 6'd0;  bb = 6'd0;  nw = 6'd1;  end
				1:       begin sb = 6'd8;  bb = 6'd6;  nw = 6'd8;  end
				2:       begin sb = 6'd15; bb = 6'd63; nw = 6'd15; end
				3:       begin sb = 6'd4;  bb = 6'd2;  nw = 6'd0;  end
				default: begin
					sb = 6'($urandom_range(0, 63));
					bb = ($urandom_range(3) == 0) ? 6'($urandom_range(0, 63))
						: 6'($urandom_range(0, 8));
					nw = 6'($urandom_range(0, 15));
				end
			endcase
			set_geometry(sb, bb, nw);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase

			// a small set of hot blocks so that lines get reused and evicted
			offs_mask = (bb >= 6'd63) ? '1 : ((64'd1 << bb) - 64'd1);
			hot.delete();
			n = $urandom_range(4, 24);
			for (i = 0; i < n; i++)
				hot.push_back({$urandom, $urandom});

			for (burst = 0; burst < 3; burst++) begin
				n = $urandom_range(30, 70);
				for (i = 0; i < n; i++) begin
					if ($urandom_range(3) != 0)
						addr = hot[$urandom_range(hot.size() - 1)] ^ ({$urandom, $urandom} & offs_mask);
					else
						addr = {$urandom, $urandom};
					pick = $urandom_range(19);
					if (pick < 6)
						queue_access(KIND_LOAD, addr);
					else if (pick < 12)
						queue_access(KIND_STORE, addr);
					else if (pick < 19)
						queue_access(KIND_MODIFY, addr);
					else
						queue_access(KIND_NONE, addr);
				end
				// let the cache run dry before the next burst
				wait_drained();
			end
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		// catch any stray result word
		repeat (20) @(posedge clk);

		$display("Checked %0d result words over %0d geometries.", checked_cnt, geometry_cnt);
		$display("Cache totals: %0d hits, %0d misses, %0d evictions.",
			hit_cnt, miss_cnt, evict_cnt);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("Timed out with %0d outcomes pending.", outcome_q.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
